>>> rtl/iba_pkg.sv
// Shared types and constants for the indexed block allocator.
// Holds the directory entry layout, operation codes and status codes.
// No dependencies.
package iba_pkg;

  // Fixed field widths of the request and response items.
  localparam int ID_W    = 16;
  localparam int BLK_W   = 6;
  localparam int MAP_W   = 64;
  localparam int COUNT_W = 5;
  localparam int NB_W    = 7;

  // Block count register after reset.
  localparam logic [NB_W-1:0] NUM_BLOCKS_RESET = 7'd64;

  // Operation codes.
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // One directory entry: file id and its index block.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [BLK_W-1:0] blk;
  } dir_entry_t;

endpackage

>>> rtl/indexed_block_allocator.sv
// Indexed block allocator: free-block bit map plus a compact file directory in a RAM.
// A create's response is presented the cycle after it is accepted.
// A delete over a directory of n entries does one RAM read per entry while searching,
// then one overlapped read and write per later entry while compacting.
// One request is in work at a time; the response register frees the input side.
// Synchronous reset clears the bit map and entry count and sets the block count to 64.
module indexed_block_allocator #(
  parameter int MAX_DISK_BLOCKS = 64,
  parameter int DIRECTORY_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [iba_pkg::NB_W-1:0]       cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [iba_pkg::ID_W-1:0]       file_id,
  input  logic [iba_pkg::BLK_W-1:0]      index_block,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [iba_pkg::BLK_W-1:0]      block_touched,
  output logic [iba_pkg::COUNT_W-1:0]    entry_count,
  output logic [iba_pkg::MAP_W-1:0]      block_map
);

  localparam int MB      = MAX_DISK_BLOCKS;
  localparam int AW      = $clog2(DIRECTORY_DEPTH);
  localparam int CW      = $clog2(DIRECTORY_DEPTH + 1);
  localparam int MAP_W   = iba_pkg::MAP_W;
  localparam int COUNT_W = iba_pkg::COUNT_W;
  localparam int NB_W    = iba_pkg::NB_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DIRECTORY_DEPTH);
  localparam logic [NB_W-1:0] MB_C  = NB_W'(MAX_DISK_BLOCKS);
  localparam logic [MB-1:0] BIT0    = MB'(1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SHIFT  = 3'b100
  } state_t;

  state_t                      state, state_next;
  logic [NB_W-1:0]             num_blocks;
  logic [MB-1:0]               alloc, alloc_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               ptr, ptr_next;
  logic                        cmp_vld, cmp_vld_next;
  logic [AW-1:0]               cmp_idx, cmp_idx_next;
  logic [iba_pkg::ID_W-1:0]    del_id;
  logic [iba_pkg::BLK_W-1:0]   found_blk, found_blk_next;
  logic                        out_valid_next;
  logic [2:0]                  status_next;
  logic [iba_pkg::BLK_W-1:0]   block_touched_next;
  logic [COUNT_W-1:0]          entry_count_next;
  logic [MAP_W-1:0]            block_map_next;
  logic [MAP_W-1:0]            map_wide;
  logic                        accept;
  logic                        blk_ok;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  iba_pkg::dir_entry_t         rd_entry;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  iba_pkg::dir_entry_t         wr_data;

  // Directory storage.
  iba_dir_ram #(
    .DEPTH (DIRECTORY_DEPTH),
    .AW    (AW)
  ) u_dir_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A new item is taken only when idle and the response register is free or draining.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign map_wide = MAP_W'(alloc);
  assign blk_ok   = (NB_W'(index_block) < num_blocks) && (NB_W'(index_block) < MB_C);

  // Request sequencing: create in one step, delete as search then compaction.
  always_comb begin
    state_next         = state;
    alloc_next         = alloc;
    count_next         = count;
    ptr_next           = ptr;
    cmp_vld_next       = cmp_vld;
    cmp_idx_next       = cmp_idx;
    found_blk_next     = found_blk;
    out_valid_next     = out_valid && !out_ready;
    status_next        = status;
    block_touched_next = block_touched;
    entry_count_next   = entry_count;
    block_map_next     = block_map;
    rd_en              = 1'b0;
    rd_addr            = ptr[AW-1:0];
    wr_en              = 1'b0;
    wr_addr            = count[AW-1:0];
    wr_data.id         = file_id;
    wr_data.blk        = index_block;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == iba_pkg::OP_CREATE) begin
            block_touched_next = '0;
            priority if (!blk_ok) begin
              status_next = iba_pkg::ST_INVALID;
            end else if (map_wide[index_block]) begin
              status_next = iba_pkg::ST_ALLOCATED;
            end else if (count == DEPTH_C) begin
              status_next = iba_pkg::ST_FULL;
            end else begin
              status_next        = iba_pkg::ST_OK;
              alloc_next         = alloc | (BIT0 << index_block);
              count_next         = count + CW'(1);
              wr_en              = 1'b1;
              block_touched_next = index_block;
            end
            entry_count_next = COUNT_W'(count_next);
            block_map_next   = MAP_W'(alloc_next);
            out_valid_next   = 1'b1;
          end else if (count == '0) begin
            status_next        = iba_pkg::ST_NOT_FOUND;
            block_touched_next = '0;
            entry_count_next   = COUNT_W'(count);
            block_map_next     = map_wide;
            out_valid_next     = 1'b1;
          end else begin
            state_next   = S_SEARCH;
            ptr_next     = '0;
            cmp_vld_next = 1'b0;
          end
        end
      end

      S_SEARCH: begin
        // Read entry ptr while comparing the entry read in the cycle before.
        rd_en = (ptr < count);
        if (cmp_vld && (rd_entry.id == del_id)) begin
          found_blk_next = rd_entry.blk;
          alloc_next     = alloc & ~(BIT0 << rd_entry.blk);
          ptr_next       = CW'(cmp_idx) + CW'(1);
          cmp_vld_next   = 1'b0;
          state_next     = S_SHIFT;
        end else if (!cmp_vld && !rd_en) begin
          status_next        = iba_pkg::ST_NOT_FOUND;
          block_touched_next = '0;
          entry_count_next   = COUNT_W'(count);
          block_map_next     = map_wide;
          out_valid_next     = 1'b1;
          state_next         = S_IDLE;
        end else begin
          if (rd_en) begin
            ptr_next = ptr + CW'(1);
          end
          cmp_vld_next = rd_en;
          cmp_idx_next = ptr[AW-1:0];
        end
      end

      S_SHIFT: begin
        // Move each later entry down by one: read at ptr, write one place lower.
        rd_en = (ptr < count);
        if (cmp_vld) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx;
          wr_data = rd_entry;
        end
        if (!rd_en && !cmp_vld) begin
          count_next         = count - CW'(1);
          status_next        = iba_pkg::ST_OK;
          block_touched_next = found_blk;
          entry_count_next   = COUNT_W'(count_next);
          block_map_next     = map_wide;
          out_valid_next     = 1'b1;
          state_next         = S_IDLE;
        end else begin
          if (rd_en) begin
            ptr_next = ptr + CW'(1);
          end
          cmp_vld_next = rd_en;
          cmp_idx_next = AW'(ptr - CW'(1));
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_blocks <= iba_pkg::NUM_BLOCKS_RESET;
      alloc      <= '0;
      count      <= '0;
      cmp_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      alloc     <= alloc_next;
      count     <= count_next;
      cmp_vld   <= cmp_vld_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        num_blocks <= cfg_wdata;
      end
    end
  end

  // Datapath and response registers.
  always_ff @(posedge clk) begin
    ptr           <= ptr_next;
    cmp_idx       <= cmp_idx_next;
    found_blk     <= found_blk_next;
    status        <= status_next;
    block_touched <= block_touched_next;
    entry_count   <= entry_count_next;
    block_map     <= block_map_next;
    if (accept) begin
      del_id <= file_id;
    end
  end

  // The entry count never passes the directory depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds directory depth");

  // Every directory entry owns exactly one allocated block between requests.
  a_map_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(alloc) == int'(count)))
    else $error("allocated block count differs from entry count");

  // Finishing a compaction removes exactly one entry.
  a_delete_decrements: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !rd_en && !cmp_vld) |=> (count == $past(count) - CW'(1)))
    else $error("delete did not remove one entry");

  // RAM writes stay below the entry count, or land at it for a create taken while idle.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < count || (state == S_IDLE && CW'(wr_addr) == count)))
    else $error("directory write outside the live entries");

  // A response appears only after a create was taken or a delete finished.
  a_response_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(accept && op == iba_pkg::OP_CREATE)
                          || $past(state != S_IDLE) || $past(accept && count == '0)))
    else $error("response without a finished request");

endmodule

>>> rtl/iba_dir_ram.sv
// Directory storage: one write port and one read port, registered read data.
// Depends on iba_pkg for the entry type.
module iba_dir_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output iba_pkg::dir_entry_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  iba_pkg::dir_entry_t wr_data
);

  iba_pkg::dir_entry_t mem [DEPTH];

  // Synchronous write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Synchronous read: the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/sv/indexed_block_allocator_tb.sv
// Self-checking testbench for the indexed block allocator.
// Depends on iba_pkg and the allocator RTL with its directory RAM.
// A scoreboard class predicts each response from its own copy of the map and directory.
module indexed_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCKS    = 64;
  localparam int DIR_DEPTH = 16;

  // Tracks the bit map and directory and queues the response each request should get.
  class allocator_scoreboard;
    typedef struct packed {
      logic [2:0]                  status;
      logic [iba_pkg::BLK_W-1:0]   touched;
      logic [iba_pkg::COUNT_W-1:0] count;
      logic [iba_pkg::MAP_W-1:0]   map;
    } alloc_result_t;

    logic [iba_pkg::MAP_W-1:0] alloc_map;
    logic [iba_pkg::ID_W-1:0]  dir_ids[DIR_DEPTH];
    logic [iba_pkg::BLK_W-1:0] dir_blocks[DIR_DEPTH];
    int unsigned               dir_count;
    logic [iba_pkg::NB_W-1:0]  block_limit;
    alloc_result_t             expected_results[$];
    int unsigned               errors;

    function new();
      alloc_map = '0;
      dir_count = 0;
      block_limit = iba_pkg::NUM_BLOCKS_RESET;
      errors = 0;
    endfunction

    function void set_blocks(logic [iba_pkg::NB_W-1:0] value);
      block_limit = value;
    endfunction

    // A block count above the disk size acts as the disk size.
    function int unsigned usable_blocks();
      return (block_limit > BLOCKS) ? BLOCKS : block_limit;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Apply one accepted request to the copy of the state and queue its response.
    function void note_request(logic kind, logic [iba_pkg::ID_W-1:0] id,
                               logic [iba_pkg::BLK_W-1:0] blk);
      alloc_result_t res;
      int            found;
      res = '0;
      if (kind == iba_pkg::OP_CREATE) begin
        if (blk >= usable_blocks()) begin
          res.status = iba_pkg::ST_INVALID;
        end else if (alloc_map[blk]) begin
          res.status = iba_pkg::ST_ALLOCATED;
        end else if (dir_count >= DIR_DEPTH) begin
          res.status = iba_pkg::ST_FULL;
        end else begin
          alloc_map[blk] = 1'b1;
          dir_ids[dir_count] = id;
          dir_blocks[dir_count] = blk;
          dir_count++;
          res.status = iba_pkg::ST_OK;
          res.touched = blk;
        end
      end else begin
        found = -1;
        for (int i = 0; i < dir_count; i++) begin
          if (found < 0 && dir_ids[i] == id) found = i;
        end
        if (found < 0) begin
          res.status = iba_pkg::ST_NOT_FOUND;
        end else begin
          // Free the entry's block, even one beyond the current block count.
          res.status = iba_pkg::ST_OK;
          res.touched = dir_blocks[found];
          alloc_map[dir_blocks[found]] = 1'b0;
          for (int i = found; i + 1 < dir_count; i++) begin
            dir_ids[i] = dir_ids[i+1];
            dir_blocks[i] = dir_blocks[i+1];
          end
          dir_count--;
        end
      end
      res.count = iba_pkg::COUNT_W'(dir_count);
      res.map = alloc_map;
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted response with the oldest expectation, field by field.
    task check_result(logic [2:0] st, logic [iba_pkg::BLK_W-1:0] touched,
                      logic [iba_pkg::COUNT_W-1:0] cnt, logic [iba_pkg::MAP_W-1:0] map);
      alloc_result_t exp_res;
      if (expected_results.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp_res = expected_results.pop_front();
        if (st !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", st, exp_res.status));
        if (touched !== exp_res.touched)
          report_mismatch($sformatf("block_touched %0d, expected %0d", touched,
                                    exp_res.touched));
        if (cnt !== exp_res.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", cnt, exp_res.count));
        if (map !== exp_res.map)
          report_mismatch($sformatf("block_map %h, expected %h", map, exp_res.map));
      end
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [iba_pkg::NB_W-1:0]    cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic                        op;
  logic [iba_pkg::ID_W-1:0]    file_id;
  logic [iba_pkg::BLK_W-1:0]   index_block;
  logic                        out_valid;
  logic                        out_ready;
  logic [2:0]                  status;
  logic [iba_pkg::BLK_W-1:0]   block_touched;
  logic [iba_pkg::COUNT_W-1:0] entry_count;
  logic [iba_pkg::MAP_W-1:0]   block_map;

  allocator_scoreboard      sb;
  logic [iba_pkg::ID_W-1:0] id_pool[8];
  bit                       calm;

  indexed_block_allocator #(
    .MAX_DISK_BLOCKS(BLOCKS),
    .DIRECTORY_DEPTH(DIR_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .file_id(file_id),
    .index_block(index_block),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .block_touched(block_touched),
    .entry_count(entry_count),
    .block_map(block_map)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Each side idles at random, roughly 37 percent of the time, except during a calm stretch.
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // Response side: random back-pressure, checked at the rising edge.
  always @(negedge clk) begin
    out_ready <= !take_gap();
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(status, block_touched, entry_count, block_map);
  end

  // Present one request, hold it until accepted, and record it at the accepting edge.
  task automatic send_request(logic kind, logic [iba_pkg::ID_W-1:0] id,
                              logic [iba_pkg::BLK_W-1:0] blk);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    file_id <= id;
    index_block <= blk;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, id, blk);
    @(negedge clk);
  endtask

  // Let every outstanding response drain, then write the block count.
  task automatic write_block_count(logic [iba_pkg::NB_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_blocks(value);
  endtask

  // Mostly well-formed requests: creates on free in-range blocks and deletes of live ids.
  task automatic send_random(int unsigned create_pct);
    int unsigned               usable;
    int                        free_list[$];
    logic                      kind;
    logic [iba_pkg::ID_W-1:0]  id;
    logic [iba_pkg::BLK_W-1:0] blk;
    kind = ($urandom_range(99) < create_pct) ? iba_pkg::OP_CREATE : iba_pkg::OP_DELETE;
    id = ($urandom_range(99) < 60) ? id_pool[$urandom_range(7)]
                                   : iba_pkg::ID_W'($urandom);
    blk = iba_pkg::BLK_W'($urandom);
    if (kind == iba_pkg::OP_CREATE) begin
      if ($urandom_range(99) < 75) begin
        usable = sb.usable_blocks();
        for (int b = 0; b < usable; b++) begin
          if (!sb.alloc_map[b]) free_list.push_back(b);
        end
        if (free_list.size() != 0)
          blk = iba_pkg::BLK_W'(free_list[$urandom_range(free_list.size() - 1)]);
      end
    end else if (sb.dir_count != 0 && $urandom_range(99) < 75) begin
      id = sb.dir_ids[$urandom_range(sb.dir_count - 1)];
    end
    send_request(kind, id, blk);
  endtask

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [iba_pkg::NB_W-1:0] phase_blocks[7];
    int unsigned              phase_create[7];
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = iba_pkg::NUM_BLOCKS_RESET;
    in_valid = 1'b0;
    op = iba_pkg::OP_CREATE;
    file_id = '0;
    index_block = '0;
    calm = 1'b0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = iba_pkg::ID_W'($urandom);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty delete, field extremes, duplicate ids and first-match delete.
    send_request(iba_pkg::OP_DELETE, 16'hFFFF, 6'd0);
    send_request(iba_pkg::OP_CREATE, 16'hFFFF, 6'd63);
    send_request(iba_pkg::OP_CREATE, 16'h0000, 6'd0);
    send_request(iba_pkg::OP_CREATE, 16'h0000, 6'd1);
    send_request(iba_pkg::OP_DELETE, 16'h0000, 6'd63);
    send_request(iba_pkg::OP_DELETE, 16'h0000, 6'd0);
    // Fill the directory, then try a free block and a taken block while full.
    for (int i = 0; i < DIR_DEPTH - 1; i++)
      send_request(iba_pkg::OP_CREATE, 16'h5A00 + iba_pkg::ID_W'(i),
                   iba_pkg::BLK_W'(i + 2));
    send_request(iba_pkg::OP_CREATE, 16'h1234, 6'd40);
    send_request(iba_pkg::OP_CREATE, 16'h1234, 6'd2);
    // A zero block count rejects every create.
    write_block_count(7'd0);
    send_request(iba_pkg::OP_CREATE, 16'hAAAA, 6'd0);
    // Out of range is reported before already allocated; delete frees a stale block.
    write_block_count(7'd2);
    send_request(iba_pkg::OP_CREATE, 16'h5555, 6'd2);
    send_request(iba_pkg::OP_DELETE, 16'hFFFF, 6'd0);

    // Random phases, each under its own block count.
    phase_blocks = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd65,
                     iba_pkg::NB_W'($urandom_range(2, 63)),
                     iba_pkg::NB_W'($urandom_range(1, 127))};
    phase_create = '{60, 50, 55, 50, 45, 65, 55};
    for (int p = 0; p < 7; p++) begin
      write_block_count(phase_blocks[p]);
      calm = (p == 2);
      for (int n = 0; n < 204; n++) send_random(phase_create[p]);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
